// File: hdl/pse_pkg.sv
// Package: shared types, codes and sizes for the postfix evaluator
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FIFO_DEPTH  = 2;

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_NUMBER = 2'd0,
        REQ_OPER   = 2'd1,
        REQ_END    = 2'd2,
        REQ_BAD    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [63:0] number_value;
        logic [1:0]         operator_code;
    } req_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
        logic               saturated;
    } rsp_t;

    // Classified command passed from front end to execution unit
    typedef struct packed {
        req_type_t   kind;
        op_code_t    op;
        logic [63:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_READ,
        EX_MUL,
        EX_DIV,
        EX_WRITE,
        EX_OUT
    } ex_state_t;

endpackage

// File: hdl/postfix_stack_evaluator_top.sv
// Top level: postfix expression evaluator with decoupled front end and execution unit
// Usage:
//   Request channel (in_valid/in_ready/in_data) carries one token per request:
//   number, operator, end of expression or malformed. Response channel
//   (out_valid/out_ready/out_data) carries one result per end token: the
//   Q32.32 value, a status code and a saturation flag.
// Flow:
//   A two-entry queue sits between the front end and the execution unit, so
//   requests are taken while the execution unit is busy.
//   Number and malformed tokens: handled in the execution unit's idle state.
//   Add/subtract: stack read, compute, write back.
//   Multiply: four 32x32 partial products on one multiplier, then write back.
//   Divide: a radix-2 divider retires one of 128 quotient bits per cycle.
//   End token: stack read, then EX_OUT loads the response register.
// Reset: clears the stack count, the flags and both channels' valid state.
//   Stack contents are not cleared.
// Stall: a held response blocks the next end token; the queue fills and
//   in_ready drops until the receiver takes the response.
module postfix_stack_evaluator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pse_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pse_pkg::rsp_t out_data
);
    logic          cmd_valid, cmd_ready;
    pse_pkg::cmd_t cmd_data;

    pse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    pse_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

// File: hdl/pse_front.sv
// Front end: accepts requests and queues classified commands
module pse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pse_pkg::req_t     in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output pse_pkg::cmd_t     cmd_data
);
    localparam int QW = $clog2(pse_pkg::FIFO_DEPTH);

    pse_pkg::cmd_t q_reg [pse_pkg::FIFO_DEPTH];
    logic [QW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QW:0]   cnt_reg, cnt_next;
    logic          push, pop;
    pse_pkg::cmd_t cmd_in;

    // Classify incoming request
    always_comb
    begin
        cmd_in.kind  = pse_pkg::req_type_t'(in_data.req_type);
        cmd_in.op    = pse_pkg::op_code_t'(in_data.operator_code);
        cmd_in.value = in_data.number_value;
    end

    assign in_ready  = (cnt_reg != (QW+1)'(pse_pkg::FIFO_DEPTH));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_data  = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cmd_in;
        end
    end
endmodule

// File: hdl/pse_exec.sv
// Execution unit: operand stack, ALU, multiplier and iterative divider
module pse_exec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pse_pkg::cmd_t cmd_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pse_pkg::rsp_t out_data
);
    localparam int CW = pse_pkg::CNT_W;
    localparam int PW = pse_pkg::PTR_W;
    localparam int FB = pse_pkg::FRAC_BITS;

    pse_pkg::ex_state_t state_reg, state_next;

    logic [63:0] stack_mem [pse_pkg::STACK_DEPTH];
    logic [63:0] rd_a_reg, rd_b_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic bad_reg, bad_next, ovf_reg, ovf_next, sat_reg, sat_next;
    pse_pkg::op_code_t op_reg, op_next;
    logic [63:0] res_reg, res_next;
    pse_pkg::rsp_t out_reg, out_next;

    // Multiply partial products, one 32x32 per cycle
    logic [1:0]   mstep_reg, mstep_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg, neg_next;
    // Divider
    logic [6:0]   dstep_reg, dstep_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  rem_reg, rem_next;
    logic [127:0] quo_reg, quo_next;

    logic         do_read, do_write, load_ops;
    logic [PW-1:0] rd_a_idx, rd_b_idx, wr_idx;
    logic [63:0]  wr_val;
    logic [63:0]  a, b, mag_a, mag_b, sum, dif, fit_val;
    logic [127:0] fit_in, mshift;
    logic [63:0]  pp;
    logic [31:0]  px, py;
    logic [64:0]  rem_sh, rem_sub;
    logic         fit_sat, take;
    logic         cnt_ok_op, stack_full;

    assign a     = rd_a_reg;
    assign b     = rd_b_reg;
    assign mag_a = a[63] ? (64'd0 - a) : a;
    assign mag_b = b[63] ? (64'd0 - b) : b;
    assign sum   = a + b;
    assign dif   = a - b;
    assign cnt_ok_op  = (cnt_reg >= CW'(2));
    assign stack_full = (cnt_reg >= CW'(pse_pkg::STACK_DEPTH));
    assign rd_b_idx   = PW'(cnt_reg - CW'(1));
    assign rd_a_idx   = PW'(cnt_reg - CW'(2));

    // Sign application with saturation
    always_comb
    begin
        fit_in  = (op_reg == pse_pkg::OP_MUL) ? mshift : quo_reg;
        fit_sat = 1'b0;
        fit_val = fit_in[63:0];
        if (neg_reg)
        begin
            if (fit_in[127:64] != '0 || fit_in[63:0] > 64'h8000_0000_0000_0000)
            begin
                fit_sat = 1'b1;
            end
            else
            begin
                fit_val = 64'd0 - fit_in[63:0];
            end
        end
        else if (fit_in[127:63] != '0)
        begin
            fit_sat = 1'b1;
        end
        if (fit_sat)
        begin
            fit_val = pse_pkg::SAT_MAX;
        end
    end

    assign mshift = acc_reg >> FB;

    // One 32x32 partial product per step
    always_comb
    begin
        case (mstep_reg)
            2'd0:    begin px = ma_reg[31:0];  py = mb_reg[31:0];  end
            2'd1:    begin px = ma_reg[31:0];  py = mb_reg[63:32]; end
            2'd2:    begin px = ma_reg[63:32]; py = mb_reg[31:0];  end
            default: begin px = ma_reg[63:32]; py = mb_reg[63:32]; end
        endcase
        pp = {32'd0, px} * {32'd0, py};
    end

    // Divider step
    assign rem_sh  = {rem_reg, num_reg[127]};
    assign take    = rem_sh >= {1'b0, mb_reg};
    assign rem_sub = rem_sh - {1'b0, mb_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::EX_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_data.kind == pse_pkg::REQ_END)
                    begin
                        state_next = pse_pkg::EX_OUT;
                    end
                    else if (cmd_data.kind == pse_pkg::REQ_OPER && !bad_reg && cnt_ok_op)
                    begin
                        state_next = pse_pkg::EX_READ;
                    end
                end
            end
            pse_pkg::EX_READ:
            begin
                if (op_reg == pse_pkg::OP_MUL)
                begin
                    state_next = pse_pkg::EX_MUL;
                end
                else if (op_reg == pse_pkg::OP_DIV && b != '0)
                begin
                    state_next = pse_pkg::EX_DIV;
                end
                else
                begin
                    state_next = pse_pkg::EX_WRITE;
                end
            end
            pse_pkg::EX_MUL:
            begin
                if (mstep_reg == 2'd3)
                begin
                    state_next = pse_pkg::EX_WRITE;
                end
            end
            pse_pkg::EX_DIV:
            begin
                if (dstep_reg == 7'd127)
                begin
                    state_next = pse_pkg::EX_WRITE;
                end
            end
            pse_pkg::EX_WRITE:
            begin
                state_next = pse_pkg::EX_IDLE;
            end
            pse_pkg::EX_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = pse_pkg::EX_IDLE;
                end
            end
            default:
            begin
                state_next = pse_pkg::EX_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_ready  = 1'b0;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        sat_next   = sat_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        neg_next   = neg_reg;
        mstep_next = mstep_reg;
        acc_next   = acc_reg;
        dstep_next = dstep_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        do_read    = 1'b0;
        load_ops   = 1'b0;
        do_write   = 1'b0;
        wr_idx     = PW'(cnt_reg);
        wr_val     = cmd_data.value;
        case (state_reg)
            pse_pkg::EX_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_data.kind)
                        pse_pkg::REQ_NUMBER:
                        begin
                            cmd_ready = 1'b1;
                            if (!bad_reg)
                            begin
                                if (stack_full)
                                begin
                                    ovf_next = 1'b1;
                                    bad_next = 1'b1;
                                end
                                else
                                begin
                                    do_write = 1'b1;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                        end
                        pse_pkg::REQ_OPER:
                        begin
                            cmd_ready = 1'b1;
                            op_next   = cmd_data.op;
                            if (!bad_reg)
                            begin
                                if (cnt_ok_op)
                                begin
                                    do_read = 1'b1;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        pse_pkg::REQ_BAD:
                        begin
                            cmd_ready = 1'b1;
                            bad_next  = 1'b1;
                        end
                        default:
                        begin
                            // end token: held until EX_OUT
                            do_read = 1'b1;
                        end
                    endcase
                end
            end
            pse_pkg::EX_READ:
            begin
                neg_next   = a[63] ^ b[63];
                load_ops   = 1'b1;
                mstep_next = 2'd0;
                acc_next   = '0;
                dstep_next = '0;
                rem_next   = '0;
                quo_next   = '0;
                num_next   = {64'd0, mag_a} << FB;
                case (op_reg)
                    pse_pkg::OP_ADD:
                    begin
                        if (a[63] == b[63] && sum[63] != a[63])
                        begin
                            res_next = pse_pkg::SAT_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = sum;
                        end
                    end
                    pse_pkg::OP_SUB:
                    begin
                        if (a[63] != b[63] && dif[63] != a[63])
                        begin
                            res_next = pse_pkg::SAT_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            res_next = dif;
                        end
                    end
                    pse_pkg::OP_DIV:
                    begin
                        if (b == '0)
                        begin
                            res_next = pse_pkg::SAT_MAX;
                            sat_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            pse_pkg::EX_MUL:
            begin
                mstep_next = mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0:    acc_next = acc_reg + {64'd0, pp};
                    2'd1:    acc_next = acc_reg + {32'd0, pp, 32'd0};
                    2'd2:    acc_next = acc_reg + {32'd0, pp, 32'd0};
                    default: acc_next = acc_reg + {pp, 64'd0};
                endcase
                if (mstep_reg == 2'd3)
                begin
                    op_next = pse_pkg::OP_MUL;
                end
            end
            pse_pkg::EX_DIV:
            begin
                dstep_next = dstep_reg + 7'd1;
                num_next   = {num_reg[126:0], 1'b0};
                if (rem_reg[63] || take)
                begin
                    rem_next = rem_sub[63:0];
                    quo_next = {quo_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    quo_next = {quo_reg[126:0], 1'b0};
                end
            end
            pse_pkg::EX_WRITE:
            begin
                do_write = 1'b1;
                wr_idx   = rd_a_idx;
                cnt_next = cnt_reg - CW'(1);
                if (op_reg == pse_pkg::OP_MUL || (op_reg == pse_pkg::OP_DIV && mb_reg != '0))
                begin
                    wr_val = fit_val;
                    if (fit_sat)
                    begin
                        sat_next = 1'b1;
                    end
                end
                else
                begin
                    wr_val = res_reg;
                end
            end
            pse_pkg::EX_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    cmd_ready = 1'b1;
                    out_next.saturated = sat_reg;
                    out_next.result_value = '0;
                    if (ovf_reg)
                    begin
                        out_next.status = pse_pkg::ST_OVERFLOW;
                    end
                    else if (bad_reg || cnt_reg != CW'(1))
                    begin
                        out_next.status = pse_pkg::ST_BAD;
                    end
                    else
                    begin
                        out_next.status = pse_pkg::ST_OK;
                        out_next.result_value = rd_b_reg;
                    end
                    cnt_next = '0;
                    bad_next = 1'b0;
                    ovf_next = 1'b0;
                    sat_next = 1'b0;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Output register holds a finished response until taken
    logic out_valid_reg, out_valid_next;
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == pse_pkg::EX_OUT && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
        end
    end
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Stack memory: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            stack_mem[wr_idx] <= wr_val;
        end
        if (do_read)
        begin
            // for an end token the entry at index zero is the lone value
            rd_b_reg <= stack_mem[(cmd_data.kind == pse_pkg::REQ_END) ? PW'(0) : rd_b_idx];
            rd_a_reg <= stack_mem[rd_a_idx];
        end
    end

    // Operand registers and datapath payload
    always_ff @(posedge clk)
    begin
        if (load_ops)
        begin
            ma_reg <= mag_a;
            mb_reg <= mag_b;
        end
        op_reg    <= op_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        mstep_reg <= mstep_next;
        dstep_reg <= dstep_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pse_pkg::EX_IDLE;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: hdl/pse_checker.sv
// Port checker for the postfix evaluator, bound to the top level
module pse_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input pse_pkg::req_t in_data,
    input logic          out_valid,
    input logic          out_ready,
    input pse_pkg::rsp_t out_data
);
    // Held response stays stable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    // Non-ok status always reports zero value
    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != pse_pkg::ST_OK |-> out_data.result_value == '0)
        else $error("value nonzero on error status");

    // Status code stays in range
    a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("illegal status code");

    // Handshake outputs are always driven to known levels
    a_hs_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("unknown handshake output");
endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/tb_postfix_stack_evaluator_top.sv
// Testbench for the postfix stack evaluator: directed table, random expressions, predictor check
module tb_postfix_stack_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1530;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    pse_pkg::req_t  in_data;
    logic           out_valid;
    logic           out_ready;
    pse_pkg::rsp_t  out_data;

    postfix_stack_evaluator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow evaluator state
    logic [63:0] eval_stack [pse_pkg::STACK_DEPTH];
    int          eval_count;
    bit          eval_bad;
    bit          eval_ovf;
    bit          eval_sat;

    pse_pkg::rsp_t result_queue [$];
    int          error_count;
    int          mismatch_count;
    int          idle_count;
    bit          quiet_mode;
    bit          hold_rx;

    function automatic logic [63:0] mag64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Sign a 128-bit magnitude and saturate when out of range
    function automatic logic [63:0] fit_signed(logic [127:0] m, bit neg);
        if (neg)
        begin
            if (m > 128'h8000_0000_0000_0000)
            begin
                eval_sat = 1'b1;
                return pse_pkg::SAT_MAX;
            end
            return 64'd0 - m[63:0];
        end
        if (m > {64'd0, pse_pkg::SAT_MAX})
        begin
            eval_sat = 1'b1;
            return pse_pkg::SAT_MAX;
        end
        return m[63:0];
    endfunction

    function automatic logic [63:0] arith_result(logic [63:0] a, logic [63:0] b,
                                                 pse_pkg::op_code_t op);
        logic [63:0]  r;
        logic [127:0] p;
        bit           neg;
        neg = a[63] ^ b[63];
        case (op)
            pse_pkg::OP_ADD:
            begin
                r = a + b;
                if (a[63] == b[63] && r[63] != a[63])
                begin
                    eval_sat = 1'b1;
                    return pse_pkg::SAT_MAX;
                end
                return r;
            end
            pse_pkg::OP_SUB:
            begin
                r = a - b;
                if (a[63] != b[63] && r[63] != a[63])
                begin
                    eval_sat = 1'b1;
                    return pse_pkg::SAT_MAX;
                end
                return r;
            end
            pse_pkg::OP_MUL:
            begin
                p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
                return fit_signed(p >> pse_pkg::FRAC_BITS, neg);
            end
            default:
            begin
                if (mag64(b) == 64'd0)
                begin
                    eval_sat = 1'b1;
                    return pse_pkg::SAT_MAX;
                end
                p = ({64'd0, mag64(a)} << pse_pkg::FRAC_BITS) / {64'd0, mag64(b)};
                return fit_signed(p, neg);
            end
        endcase
    endfunction

    // Advance the shadow evaluator by one token; end tokens queue a result
    task automatic eval_token(pse_pkg::req_t t);
        pse_pkg::rsp_t r;
        case (pse_pkg::req_type_t'(t.req_type))
            pse_pkg::REQ_END:
            begin
                r.saturated    = eval_sat;
                r.result_value = '0;
                if (eval_ovf)
                    r.status = pse_pkg::ST_OVERFLOW;
                else if (eval_bad || eval_count != 1)
                    r.status = pse_pkg::ST_BAD;
                else
                begin
                    r.status       = pse_pkg::ST_OK;
                    r.result_value = eval_stack[0];
                end
                result_queue.push_back(r);
                eval_count = 0;
                eval_bad   = 0;
                eval_ovf   = 0;
                eval_sat   = 0;
            end
            pse_pkg::REQ_BAD: eval_bad = 1'b1;
            pse_pkg::REQ_NUMBER:
            begin
                if (!eval_bad)
                begin
                    if (eval_count >= pse_pkg::STACK_DEPTH)
                    begin
                        eval_ovf = 1'b1;
                        eval_bad = 1'b1;
                    end
                    else
                    begin
                        eval_stack[eval_count] = t.number_value;
                        eval_count++;
                    end
                end
            end
            default:
            begin
                if (!eval_bad)
                begin
                    if (eval_count < 2)
                        eval_bad = 1'b1;
                    else
                    begin
                        eval_stack[eval_count-2] = arith_result(eval_stack[eval_count-2],
                            eval_stack[eval_count-1], pse_pkg::op_code_t'(t.operator_code));
                        eval_count--;
                    end
                end
            end
        endcase
    endtask

    // Send one request, idling at random before it with valid low; valid stays up otherwise
    task automatic send_req(pse_pkg::req_t t);
        while (!quiet_mode && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        eval_token(t);
    endtask

    function automatic pse_pkg::req_t mk(pse_pkg::req_type_t k, logic [63:0] v,
                                         pse_pkg::op_code_t op);
        pse_pkg::req_t t;
        t.req_type      = k;
        t.number_value  = v;
        t.operator_code = op;
        return t;
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'h7FFF_FFFF_FFFF_FFFF;
            1: v = 64'h8000_0000_0000_0000;
            2: v = 64'd0;
            3: v = {{32{v[63]}}, v[31:0]} >>> $urandom_range(0, 16);
            4: v = {{24{v[63]}}, v[39:0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_num(logic [63:0] v);
        send_req(mk(pse_pkg::REQ_NUMBER, v, pse_pkg::op_code_t'($urandom_range(0, 3))));
    endtask

    task automatic send_op(pse_pkg::op_code_t op);
        send_req(mk(pse_pkg::REQ_OPER, rand_value(), op));
    endtask

    task automatic send_end();
        send_req(mk(pse_pkg::REQ_END, rand_value(), pse_pkg::op_code_t'($urandom_range(0, 3))));
    endtask

    // Well-formed expression with random content
    task automatic send_expr(int n_ops);
        send_num(rand_value());
        for (int i = 0; i < n_ops; i++)
        begin
            send_num(rand_value());
            send_op(pse_pkg::op_code_t'($urandom_range(0, 3)));
        end
        send_end();
    endtask

    // Directed table; expected rows are checked against fixed values too
    typedef struct {
        pse_pkg::req_t tok;
        bit            has_exp;
        pse_pkg::rsp_t exp;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic add_row(pse_pkg::req_t t, bit he, logic [63:0] v, pse_pkg::status_t s,
                           bit sat);
        dir_row_t r;
        r.tok                = t;
        r.has_exp            = he;
        r.exp.result_value   = v;
        r.exp.status         = s;
        r.exp.saturated      = sat;
        dir_rows.push_back(r);
    endtask

    // Response sink with random stalls and one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                out_ready <= 1'b0;
            else
                out_ready <= quiet_mode ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
    end

    // Compare accepted responses with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            pse_pkg::rsp_t e;
            if (result_queue.size() == 0)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected response %h", out_data);
            end
            else
            begin
                e = result_queue.pop_front();
                if (out_data.result_value !== e.result_value || out_data.status !== e.status
                    || out_data.saturated !== e.saturated)
                begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: exp value %h st %0d sat %0d, got %h st %0d sat %0d",
                            e.result_value, e.status, e.saturated, out_data.result_value,
                            out_data.status, out_data.saturated);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("postfix_stack_evaluator_top test failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps going
    initial
    begin
        hold_rx = 1'b0;
        wait (dir_rows.size() > 0 && rst_n);
        repeat (3000) @(posedge clk);
        hold_rx = 1'b1;
        repeat (800) @(posedge clk);
        hold_rx = 1'b0;
    end

    initial
    begin
        dir_row_t row;
        int       n;
        logic [63:0] one;
        one            = 64'h1_0000_0000;
        in_valid       = 1'b0;
        in_data        = '0;
        rst_n          = 1'b0;
        error_count    = 0;
        mismatch_count = 0;
        idle_count     = 0;
        quiet_mode     = 0;
        eval_count     = 0;
        eval_bad       = 0;
        eval_ovf       = 0;
        eval_sat       = 0;

        // End right after reset, lone number, max+max, div by zero, mul, errors
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, '0, pse_pkg::ST_BAD, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, 64'h8000_0000_0000_0000, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, 64'h8000_0000_0000_0000,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, pse_pkg::SAT_MAX, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, pse_pkg::SAT_MAX, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, pse_pkg::SAT_MAX,
            pse_pkg::ST_OK, 1);
        add_row(mk(pse_pkg::REQ_NUMBER, 64'hFFFF_FFFF_0000_0000, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, '0, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_DIV), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, pse_pkg::SAT_MAX,
            pse_pkg::ST_OK, 1);
        add_row(mk(pse_pkg::REQ_NUMBER, 3 * one, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, 64'hFFFF_FFFE_8000_0000, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_MUL), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, 7 * one, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_SUB), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, 64'hFFFF_FFFF_FFFF_FFFD, pse_pkg::OP_ADD), 0, '0,
            pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_DIV), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_OPER, '0, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, '0, pse_pkg::ST_BAD, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, one, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_BAD, '0, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_NUMBER, one, pse_pkg::OP_ADD), 0, '0, pse_pkg::ST_OK, 0);
        add_row(mk(pse_pkg::REQ_END, '0, pse_pkg::OP_ADD), 1, '0, pse_pkg::ST_BAD, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_req(row.tok);
            if (row.has_exp && result_queue[$] != row.exp)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("directed row %0d: exp %h st %0d sat %0d, predictor %h st %0d sat %0d",
                        i, row.exp.result_value, row.exp.status, row.exp.saturated,
                        result_queue[$].result_value, result_queue[$].status,
                        result_queue[$].saturated);
            end
        end

        // Stack overflow: 65 pushes, then an operator after the overflow is ignored
        for (int i = 0; i <= pse_pkg::STACK_DEPTH; i++)
            send_num(rand_value());
        send_op(pse_pkg::OP_ADD);
        send_end();
        // Full stack, reduced back to one value
        for (int i = 0; i < pse_pkg::STACK_DEPTH; i++)
            send_num(rand_value());
        for (int i = 1; i < pse_pkg::STACK_DEPTH; i++)
            send_op(pse_pkg::op_code_t'($urandom_range(0, 2)));
        send_end();

        // Random part: mostly well-formed expressions, some noise
        n = 0;
        while (n < N_RANDOM)
        begin
            quiet_mode = (n > 600 && n < 900);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_req(mk(pse_pkg::req_type_t'($urandom_range(0, 3)), rand_value(),
                        pse_pkg::op_code_t'($urandom_range(0, 3))));
                    n++;
                end
                1:
                begin
                    for (int k = $urandom_range(0, 3); k > 0; k--)
                    begin
                        send_num(rand_value());
                        n++;
                    end
                    send_op(pse_pkg::op_code_t'($urandom_range(0, 3)));
                    send_end();
                    n += 2;
                end
                default:
                begin
                    int ops;
                    ops = $urandom_range(0, 4);
                    send_expr(ops);
                    n += 2 * ops + 2;
                end
            endcase
        end
        in_valid  <= 1'b0;
        quiet_mode = 0;

        wait (result_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("postfix_stack_evaluator_top test passed");
        else
            $display("postfix_stack_evaluator_top test failed");
        $finish;
    end
endmodule
